@@ rtl/core/rect_and_thick_line_to_triangles_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle / thick line triangle expander
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef RECT_AND_THICK_LINE_TO_TRIANGLES_MACROS_SVH
`define RECT_AND_THICK_LINE_TO_TRIANGLES_MACROS_SVH

// Property checked while out of reset
`define RTLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included
`define RTLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/rtlt_pkg.sv @@
// ----------------------------------------------------------------------------
// rtlt_pkg
// Widths, types and helpers for the rectangle / thick line expander.
// ----------------------------------------------------------------------------
package rtlt_pkg;

  localparam int unsigned COORD_W  = 21;  // signed Q16.4 coordinate
  localparam int unsigned LW_W     = 12;  // unsigned Q8.4 thickness
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned MAG_W    = 21;  // |b - a| fits 21 bits
  localparam int unsigned SQ_W     = 2 * MAG_W;
  localparam int unsigned SUM_W    = SQ_W + 1;
  localparam int unsigned EXT_FRAC = 10;  // extra fraction bits of the length
  localparam int unsigned RAD_W    = 64;  // radicand S << 2*EXT_FRAC
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 3;
  localparam int unsigned PROD_W   = MAG_W + LW_W;
  localparam int unsigned QUOT_W   = 12;  // normal magnitude is at most t/2 rounded
  localparam int unsigned DEN_W    = ROOT_W + 1;
  localparam int unsigned DIV_W    = PROD_W + EXT_FRAC + 2;
  localparam int unsigned CORNER_N = 4;
  localparam int unsigned VERT_N   = 6;
  localparam int unsigned CNT_W    = $clog2(VERT_N);
  localparam int unsigned CSEL_W   = $clog2(CORNER_N);

  localparam logic [CNT_W-1:0] LAST_VERT = CNT_W'(VERT_N - 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Command data that travels alongside the arithmetic
  typedef struct packed {
    logic                op;
    coord_t              ax;
    coord_t              ay;
    coord_t              bx;
    coord_t              by;
    logic [LW_W-1:0]     lw;
    logic [COLOR_W-1:0]  color;
    logic                neg_dx;
    logic                neg_dy;
    logic                degen;
    logic [PROD_W-1:0]   prod_x;  // |dy| * t, feeds nx
    logic [PROD_W-1:0]   prod_y;  // |dx| * t, feeds ny
  } side_t;

  // Triangle list order v0,v1,v2,v0,v2,v3
  function automatic logic [CSEL_W-1:0] corner_sel(input logic [CNT_W-1:0] idx);
    logic [CSEL_W-1:0] c;
    case (idx)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd0;
      3'd4:    c = 2'd2;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // Clamp a one-bit-wider sum into the coordinate range
  function automatic coord_t sat_coord(input logic signed [COORD_W:0] v);
    coord_t r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/rect_and_thick_line_to_triangles.sv @@
// ----------------------------------------------------------------------------
// rect_and_thick_line_to_triangles
// Expands a solid rectangle or thick line command into two triangles.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  cmd      | in        | cmd_valid_i / cmd_stall_o | op, pos_a/b, line_width, color
//  vertex   | out       | vertex_valid_o / _stall_i | vertex_x/y, color, last_vertex
//
//  A command passes 49 register stages: 2 for difference and squares,
//  1 for the sum of squares, 32 for the one-bit-per-stage square root,
//  13 for the two dividers for the normal and 1 for the corners, then
//  the vertex buffer. The single vertex port sets throughput, as each
//  command yields six vertices there; empty commands are dropped in the
//  pipeline and cost no output cycles.
//  Reset clears all valid bits; data registers are not reset.
//  When a quad waits at the corner stage and the vertex buffer is busy,
//  the whole pipeline holds.
module rect_and_thick_line_to_triangles (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_stall_o,
  input  logic                          op_i,
  input  rtlt_pkg::coord_t              pos_a_x_i,
  input  rtlt_pkg::coord_t              pos_a_y_i,
  input  rtlt_pkg::coord_t              pos_b_x_i,
  input  rtlt_pkg::coord_t              pos_b_y_i,
  input  logic [rtlt_pkg::LW_W-1:0]     line_width_i,
  input  logic [rtlt_pkg::COLOR_W-1:0]  color_i,
  output logic                          vertex_valid_o,
  input  logic                          vertex_stall_i,
  output rtlt_pkg::coord_t              vertex_x_o,
  output rtlt_pkg::coord_t              vertex_y_o,
  output logic [rtlt_pkg::COLOR_W-1:0]  vertex_color_o,
  output logic                          last_vertex_o
);
  import rtlt_pkg::*;

  logic adv;

  // --------------------------------------------------------------------------
  // Stage 1: differences and magnitudes
  // --------------------------------------------------------------------------
  logic signed [COORD_W:0] dx_w, dy_w;
  logic [COORD_W:0]        mdx_w, mdy_w;
  logic                    s1_v_q;
  side_t                   s1_q, s1_d;
  logic [MAG_W-1:0]        s1_mdx_q, s1_mdy_q;

  always_comb begin
    dx_w  = {pos_b_x_i[COORD_W-1], pos_b_x_i} - {pos_a_x_i[COORD_W-1], pos_a_x_i};
    dy_w  = {pos_b_y_i[COORD_W-1], pos_b_y_i} - {pos_a_y_i[COORD_W-1], pos_a_y_i};
    mdx_w = dx_w[COORD_W] ? (~dx_w + 1'b1) : dx_w;
    mdy_w = dy_w[COORD_W] ? (~dy_w + 1'b1) : dy_w;
    s1_d        = '0;
    s1_d.op     = op_i;
    s1_d.ax     = pos_a_x_i;
    s1_d.ay     = pos_a_y_i;
    s1_d.bx     = pos_b_x_i;
    s1_d.by     = pos_b_y_i;
    s1_d.lw     = line_width_i;
    s1_d.color  = color_i;
    s1_d.neg_dx = dx_w[COORD_W];
    s1_d.neg_dy = dy_w[COORD_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= s1_d;
      s1_mdx_q <= mdx_w[MAG_W-1:0];
      s1_mdy_q <= mdy_w[MAG_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares and thickness products
  // --------------------------------------------------------------------------
  logic             s2_v_q;
  side_t            s2_q, s2_d;
  logic [SQ_W-1:0]  s2_sqx_q, s2_sqy_q;

  always_comb begin
    s2_d        = s1_q;
    s2_d.prod_x = PROD_W'(s1_mdy_q) * PROD_W'(s1_q.lw);
    s2_d.prod_y = PROD_W'(s1_mdx_q) * PROD_W'(s1_q.lw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q     <= s2_d;
      s2_sqx_q <= SQ_W'(s1_mdx_q) * SQ_W'(s1_mdx_q);
      s2_sqy_q <= SQ_W'(s1_mdy_q) * SQ_W'(s1_mdy_q);
    end
  end

  // --------------------------------------------------------------------------
  // Square root pipeline, one root bit per stage
  // --------------------------------------------------------------------------
  logic              sq_v_q    [0:ROOT_W];
  logic [RAD_W-1:0]  sq_rad_q  [0:ROOT_W];
  logic [REM_W-1:0]  sq_rem_q  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root_q [0:ROOT_W];
  side_t             sq_side_q [0:ROOT_W];
  logic [SUM_W-1:0]  sum_w;
  side_t             sq_in_w;

  // Sum of squares; zero length turns the line into a square
  always_comb begin
    sum_w         = SUM_W'(s2_sqx_q) + SUM_W'(s2_sqy_q);
    sq_in_w       = s2_q;
    sq_in_w.degen = (sum_w == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      sq_v_q[0] <= s2_v_q;
    end
  end

  // Radicand is S with 2*EXT_FRAC extra fraction bits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rad_q[0]  <= RAD_W'({sum_w, {(2*EXT_FRAC){1'b0}}});
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_side_q[0] <= sq_in_w;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0] trial_rem, trial;
    logic             fit;

    always_comb begin
      trial_rem = {sq_rem_q[k][REM_W-3:0], sq_rad_q[k][RAD_W-1 -: 2]};
      trial     = {1'b0, sq_root_q[k], 2'b01};
      fit       = (trial_rem >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rad_q[k+1]  <= {sq_rad_q[k][RAD_W-3:0], 2'b00};
        sq_rem_q[k+1]  <= fit ? (trial_rem - trial) : trial_rem;
        sq_root_q[k+1] <= {sq_root_q[k][ROOT_W-2:0], fit};
        sq_side_q[k+1] <= sq_side_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Normal dividers: q = (prod * 2^10 + L) / (2L), one quotient bit per stage
  // --------------------------------------------------------------------------
  logic              dv_v_q    [0:QUOT_W];
  logic [DIV_W-1:0]  dv_remx_q [0:QUOT_W];
  logic [DIV_W-1:0]  dv_remy_q [0:QUOT_W];
  logic [QUOT_W-1:0] dv_qx_q   [0:QUOT_W];
  logic [QUOT_W-1:0] dv_qy_q   [0:QUOT_W];
  logic [DEN_W-1:0]  dv_den_q  [0:QUOT_W];
  side_t             dv_side_q [0:QUOT_W];
  logic [ROOT_W-1:0] len_w;

  assign len_w = sq_root_q[ROOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= sq_v_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_remx_q[0] <= DIV_W'({sq_side_q[ROOT_W].prod_x, {EXT_FRAC{1'b0}}}) + DIV_W'(len_w);
      dv_remy_q[0] <= DIV_W'({sq_side_q[ROOT_W].prod_y, {EXT_FRAC{1'b0}}}) + DIV_W'(len_w);
      dv_qx_q[0]   <= '0;
      dv_qy_q[0]   <= '0;
      dv_den_q[0]  <= {len_w, 1'b0};
      dv_side_q[0] <= sq_side_q[ROOT_W];
    end
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    localparam int unsigned SH = QUOT_W - 1 - k;
    logic [DIV_W-1:0] den_sh;
    logic             fitx, fity;

    always_comb begin
      den_sh = DIV_W'(dv_den_q[k]) << SH;
      fitx   = (dv_remx_q[k] >= den_sh);
      fity   = (dv_remy_q[k] >= den_sh);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_remx_q[k+1] <= fitx ? (dv_remx_q[k] - den_sh) : dv_remx_q[k];
        dv_remy_q[k+1] <= fity ? (dv_remy_q[k] - den_sh) : dv_remy_q[k];
        dv_qx_q[k+1]   <= {dv_qx_q[k][QUOT_W-2:0], fitx};
        dv_qy_q[k+1]   <= {dv_qy_q[k][QUOT_W-2:0], fity};
        dv_den_q[k+1]  <= dv_den_q[k];
        dv_side_q[k+1] <= dv_side_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Corner stage: rectangle or offset line corners, saturated
  // --------------------------------------------------------------------------
  side_t                   cs_w;
  logic                    rect_w, empty_w;
  coord_t                  w_w, h_w;
  logic signed [COORD_W:0] nx_w, ny_w;
  coord_t                  cx_w [CORNER_N];
  coord_t                  cy_w [CORNER_N];
  logic                    cn_v_q, cn_empty_q;
  coord_t                  cn_x_q [CORNER_N];
  coord_t                  cn_y_q [CORNER_N];
  logic [COLOR_W-1:0]      cn_color_q;

  always_comb begin
    cs_w    = dv_side_q[QUOT_W];
    rect_w  = !cs_w.op || cs_w.degen;
    w_w     = cs_w.op ? coord_t'(cs_w.lw) : cs_w.bx;
    h_w     = cs_w.op ? coord_t'(cs_w.lw) : cs_w.by;
    empty_w = rect_w && ((w_w <= 0) || (h_w <= 0));
    // nx opposes the sign of dy, ny follows dx
    nx_w = cs_w.neg_dy ? (COORD_W+1)'(dv_qx_q[QUOT_W])
                       : -(COORD_W+1)'(dv_qx_q[QUOT_W]);
    ny_w = cs_w.neg_dx ? -(COORD_W+1)'(dv_qy_q[QUOT_W])
                       : (COORD_W+1)'(dv_qy_q[QUOT_W]);
    if (rect_w) begin
      cx_w[0] = cs_w.ax;
      cy_w[0] = cs_w.ay;
      cx_w[1] = sat_coord({cs_w.ax[COORD_W-1], cs_w.ax} + {w_w[COORD_W-1], w_w});
      cy_w[1] = cs_w.ay;
      cx_w[2] = cx_w[1];
      cy_w[2] = sat_coord({cs_w.ay[COORD_W-1], cs_w.ay} + {h_w[COORD_W-1], h_w});
      cx_w[3] = cs_w.ax;
      cy_w[3] = cy_w[2];
    end else begin
      cx_w[0] = sat_coord({cs_w.ax[COORD_W-1], cs_w.ax} + nx_w);
      cy_w[0] = sat_coord({cs_w.ay[COORD_W-1], cs_w.ay} + ny_w);
      cx_w[1] = sat_coord({cs_w.bx[COORD_W-1], cs_w.bx} + nx_w);
      cy_w[1] = sat_coord({cs_w.by[COORD_W-1], cs_w.by} + ny_w);
      cx_w[2] = sat_coord({cs_w.bx[COORD_W-1], cs_w.bx} - nx_w);
      cy_w[2] = sat_coord({cs_w.by[COORD_W-1], cs_w.by} - ny_w);
      cx_w[3] = sat_coord({cs_w.ax[COORD_W-1], cs_w.ax} - nx_w);
      cy_w[3] = sat_coord({cs_w.ay[COORD_W-1], cs_w.ay} - ny_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cn_v_q <= 1'b0;
    end else if (adv) begin
      cn_v_q <= dv_v_q[QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cn_empty_q <= empty_w;
      cn_x_q     <= cx_w;
      cn_y_q     <= cy_w;
      cn_color_q <= cs_w.color;
    end
  end

  // --------------------------------------------------------------------------
  // Vertex buffer: holds one quad and walks the six vertices
  // --------------------------------------------------------------------------
  logic               eb_v_q, eb_v_d;
  logic [CNT_W-1:0]   eb_cnt_q, eb_cnt_d;
  coord_t             eb_x_q [CORNER_N];
  coord_t             eb_y_q [CORNER_N];
  logic [COLOR_W-1:0] eb_color_q;
  logic               done, free, load;
  logic [CSEL_W-1:0]  sel;

  always_comb begin
    done = eb_v_q && !vertex_stall_i && (eb_cnt_q == LAST_VERT);
    free = !eb_v_q || done;
    load = cn_v_q && !cn_empty_q && free;
    adv  = !cn_v_q || cn_empty_q || free;
    if (load) begin
      eb_v_d   = 1'b1;
      eb_cnt_d = '0;
    end else if (eb_v_q && !vertex_stall_i) begin
      eb_v_d   = !done;
      eb_cnt_d = eb_cnt_q + 1'b1;
    end else begin
      eb_v_d   = eb_v_q;
      eb_cnt_d = eb_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eb_v_q   <= 1'b0;
      eb_cnt_q <= '0;
    end else begin
      eb_v_q   <= eb_v_d;
      eb_cnt_q <= eb_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      eb_x_q     <= cn_x_q;
      eb_y_q     <= cn_y_q;
      eb_color_q <= cn_color_q;
    end
  end

  // Output ports
  assign sel            = corner_sel(eb_cnt_q);
  assign cmd_stall_o    = !adv;
  assign vertex_valid_o = eb_v_q;
  assign vertex_x_o     = eb_x_q[sel];
  assign vertex_y_o     = eb_y_q[sel];
  assign vertex_color_o = eb_color_q;
  assign last_vertex_o  = (eb_cnt_q == LAST_VERT);

endmodule

@@ rtl/core/rtlt_checker.sv @@
// ----------------------------------------------------------------------------
// rtlt_checker
// Port-level checks for the rectangle / thick line expander.
// ----------------------------------------------------------------------------
`include "rect_and_thick_line_to_triangles_macros.svh"

module rtlt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_valid_i,
  input logic                          cmd_stall_o,
  input logic                          vertex_valid_o,
  input logic                          vertex_stall_i,
  input rtlt_pkg::coord_t              vertex_x_o,
  input rtlt_pkg::coord_t              vertex_y_o,
  input logic [rtlt_pkg::COLOR_W-1:0]  vertex_color_o,
  input logic                          last_vertex_o
);

  // Stalled vertex holds its payload
  `RTLT_ASSERT(a_vtx_hold, vertex_valid_o && vertex_stall_i |=> vertex_valid_o && $stable(vertex_x_o) && $stable(vertex_y_o) && $stable(last_vertex_o), "vertex changed while stalled")

  // Within one quad the next vertex follows at once with the same color
  `RTLT_ASSERT(a_quad_run, vertex_valid_o && !vertex_stall_i && !last_vertex_o |=> vertex_valid_o && $stable(vertex_color_o), "quad broken or color changed")

  // No vertex right out of reset
  `RTLT_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !vertex_valid_o, "vertex valid after reset")

  // With the vertex buffer empty, commands are taken
  `RTLT_ASSERT(a_no_dead_stall, !vertex_valid_o |-> !cmd_stall_o, "input stalled with empty output")

endmodule

bind rect_and_thick_line_to_triangles rtlt_checker u_rtlt_checker (.*);

@@ tb/tb_rect_and_thick_line_to_triangles.sv @@
// ----------------------------------------------------------------------------
// tb_rect_and_thick_line_to_triangles
// Drives rectangle and thick line commands with random idling on both sides
// and checks every vertex against a local model of the quad expansion.
// ----------------------------------------------------------------------------
module tb_rect_and_thick_line_to_triangles;
  import rtlt_pkg::*;

  localparam logic OP_RECT = 1'b0;
  localparam logic OP_LINE = 1'b1;

  typedef struct {
    coord_t      x;
    coord_t      y;
    logic [31:0] color;
    logic        last;
  } vertex_t;

  // Holds the vertices expected from accepted commands, oldest first
  class vertex_board;
    vertex_t pending[$];
    int      errors;

    function longint clamp(longint v);
      if (v > 1048575) return 1048575;
      if (v < -1048576) return -1048576;
      return v;
    endfunction

    function longint isqrt(longint unsigned n);
      longint unsigned res, bit_v;
      res   = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n   = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return longint'(res);
    endfunction

    function longint half_normal(longint d, longint t, longint len);
      longint unsigned mag, q;
      mag = (d < 0) ? -d : d;
      q   = (((mag * t) << 10) + len) / (2 * len);
      return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void push_quad(longint cx[4], longint cy[4], logic [31:0] col);
      int order[6] = '{0, 1, 2, 0, 2, 3};
      vertex_t v;
      for (int k = 0; k < 6; k++) begin
        v.x     = coord_t'(clamp(cx[order[k]]));
        v.y     = coord_t'(clamp(cy[order[k]]));
        v.color = col;
        v.last  = (k == 5);
        pending = {pending, v};
      end
    endfunction

    function void push_rect(longint x, longint y, longint w, longint h, logic [31:0] col);
      longint cx[4], cy[4], x1, y1;
      if (w <= 0 || h <= 0) return;
      x1 = clamp(x + w);
      y1 = clamp(y + h);
      cx = '{x, x1, x1, x};
      cy = '{y, y, y1, y1};
      push_quad(cx, cy, col);
    endfunction

    // Note one accepted command
    function void note_command(logic op, coord_t ax, coord_t ay, coord_t bx, coord_t by,
                               logic [11:0] t, logic [31:0] col);
      longint dx, dy, s, len, nx, ny, cx[4], cy[4];
      if (op == OP_RECT) begin
        push_rect(ax, ay, bx, by, col);
        return;
      end
      dx = longint'(bx) - longint'(ax);
      dy = longint'(by) - longint'(ay);
      s  = dx * dx + dy * dy;
      if (s == 0) begin
        push_rect(ax, ay, t, t, col);
        return;
      end
      len = isqrt(s << 20);
      nx  = -half_normal(dy, t, len);
      ny  = half_normal(dx, t, len);
      cx  = '{ax + nx, bx + nx, bx - nx, ax - nx};
      cy  = '{ay + ny, by + ny, by - ny, ay - ny};
      push_quad(cx, cy, col);
    endfunction

    // Compare one accepted vertex with the oldest expectation
    function void check_vertex(coord_t x, coord_t y, logic [31:0] col, logic last);
      vertex_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d", $time, x, y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
        $display("%0t: vertex_x expected %0d actual %0d", $time, e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $display("%0t: vertex_y expected %0d actual %0d", $time, e.y, y);
        errors++;
      end
      if (col !== e.color) begin
        $display("%0t: vertex_color expected %h actual %h", $time, e.color, col);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_vertex expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cmd_valid_i = 1'b0;
  logic        cmd_stall_o;
  logic        op_i = 1'b0;
  coord_t      pos_a_x_i = '0, pos_a_y_i = '0, pos_b_x_i = '0, pos_b_y_i = '0;
  logic [11:0] line_width_i = '0;
  logic [31:0] color_i = '0;
  logic        vertex_valid_o;
  logic        vertex_stall_i = 1'b0;
  coord_t      vertex_x_o, vertex_y_o;
  logic [31:0] vertex_color_o;
  logic        last_vertex_o;
  logic        calm = 1'b0;  // no idling on either side while set

  vertex_board board = new();

  rect_and_thick_line_to_triangles u_top (.*);

  always #5 clk_i = ~clk_i;

  // Vertex side: random stall, check on each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && vertex_valid_o && !vertex_stall_i)
      board.check_vertex(vertex_x_o, vertex_y_o, vertex_color_o, last_vertex_o);
  end

  always @(negedge clk_i) begin
    vertex_stall_i <= !calm && ($urandom_range(99) < 26);
  end

  // Send one command, with a random idle gap before it; valid stays high
  // between back to back commands
  task automatic send_command(logic op, coord_t ax, coord_t ay, coord_t bx, coord_t by,
                              logic [11:0] t, logic [31:0] col);
    while (!calm && $urandom_range(99) < 26) begin
      cmd_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cmd_valid_i  <= 1'b1;
    op_i         <= op;
    pos_a_x_i    <= ax;
    pos_a_y_i    <= ay;
    pos_b_x_i    <= bx;
    pos_b_y_i    <= by;
    line_width_i <= t;
    color_i      <= col;
    do @(posedge clk_i); while (cmd_stall_o);
    board.note_command(op, ax, ay, bx, by, t, col);
    @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(200)) - 100);
      2: return $urandom_range(1) ? COORD_MAX - coord_t'($urandom_range(40))
                                  : COORD_MIN + coord_t'($urandom_range(40));
      default: return coord_t'(int'($urandom_range(32000)) - 16000);
    endcase
  endfunction

  task automatic drain();
    cmd_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  initial begin
    int     m;
    coord_t ax, ay;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, empty rectangles, degenerate and zero-width lines
    send_command(OP_RECT, 0, 0, 16, 32, 0, 32'h11223344);
    send_command(OP_RECT, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, 12'hFFF, 32'hFFFFFFFF);
    send_command(OP_RECT, COORD_MIN, COORD_MAX, 1, COORD_MAX, 0, 32'h0);
    send_command(OP_RECT, 5, 5, 0, 10, 0, 32'hA5A5A5A5);
    send_command(OP_RECT, 5, 5, 10, -1, 0, 32'h5A5A5A5A);
    send_command(OP_RECT, 5, 5, COORD_MIN, COORD_MIN, 0, 32'h1);
    send_command(OP_LINE, 0, 0, 160, 0, 32, 32'h01020304);
    send_command(OP_LINE, 0, 0, 0, -160, 32, 32'h05060708);
    send_command(OP_LINE, 10, 20, 10, 20, 48, 32'h090A0B0C);
    send_command(OP_LINE, 10, 20, 10, 20, 0, 32'h0D0E0F10);
    send_command(OP_LINE, 0, 0, 100, 100, 0, 32'h11111111);
    send_command(OP_LINE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 12'hFFF, 32'h22222222);
    send_command(OP_LINE, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 12'hFFF, 32'h33333333);
    send_command(OP_LINE, COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX, 12'hFFF, 32'h4);
    send_command(OP_LINE, COORD_MIN, 0, COORD_MIN, 1, 12'hFFF, 32'h5);
    send_command(OP_LINE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 12'hFFF, 32'h6);
    send_command(OP_LINE, -7, 3, 9, -13, 12'h555, 32'h77777777);
    send_command(OP_LINE, 3, -7, -13, 9, 12'hAAA, 32'h88888888);

    // Sender holds off until every vertex is out
    drain();

    // Random commands; a calm stretch in the middle
    for (int i = 0; i < 360; i++) begin
      calm = (i >= 150 && i < 200);
      m  = $urandom_range(3);
      ax = rand_coord(m);
      ay = rand_coord(m);
      if ($urandom_range(1)) begin
        if ($urandom_range(9) == 0)
          send_command(OP_LINE, ax, ay, ax, ay, 12'($urandom), $urandom);
        else
          send_command(OP_LINE, ax, ay,
                       $urandom_range(3) == 0 ? rand_coord(0) : ax + rand_coord(m),
                       $urandom_range(3) == 0 ? rand_coord(0) : ay + rand_coord(m),
                       12'($urandom), $urandom);
      end else begin
        send_command(OP_RECT, ax, ay,
                     $urandom_range(7) == 0 ? rand_coord(0) : coord_t'($urandom_range(4000)),
                     $urandom_range(7) == 0 ? rand_coord(0) : coord_t'($urandom_range(4000)),
                     12'($urandom), $urandom);
      end
    end
    calm = 1'b0;

    drain();
    if (board.errors == 0)
      $display("tb_rect_and_thick_line_to_triangles: clean");
    else
      $display("tb_rect_and_thick_line_to_triangles: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_rect_and_thick_line_to_triangles: errors");
    $finish;
  end

endmodule
